// ===== src/sags_pkg.sv =====
// Shared types and constants for the slot allocator with generation store.
// Used by the channel interfaces, the first-free encoder and the top level.
package sags_pkg;

	localparam int NUM_SLOTS   = 256;
	localparam int NUM_THREADS = 4;
	localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int ENT_DEPTH   = NUM_SLOTS * NUM_THREADS;
	localparam int ENT_W       = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;
	localparam int GEN_W       = 32;
	localparam int DATA_W      = 64;
	localparam int OP_W        = 2;
	localparam int THREAD_W    = 2;
	localparam int INDEX_W     = 9;
	localparam int OUT_SLOT_W  = 8;
	localparam int ERR_W       = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_GET   = 2'd2,
		OP_SET   = 2'd3
	} op_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE     = 2'd0,
		ERR_INVALID  = 2'd1,
		ERR_NO_SLOTS = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RMW
	} state_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
	} free_t;

	typedef struct packed {
		logic [GEN_W-1:0]  gen;
		logic [DATA_W-1:0] value;
	} entry_t;

endpackage

// ===== src/sags_if.sv =====
// Request and response channel interfaces (valid/ready with payload).
// Depends on sags_pkg for field widths.
interface sags_req_if;
	logic                          valid;
	logic                          ready;
	logic [sags_pkg::OP_W-1:0]     op;
	logic [sags_pkg::THREAD_W-1:0] thread;
	logic [sags_pkg::INDEX_W-1:0]  index;
	logic [sags_pkg::DATA_W-1:0]   data_in;

	modport source(output valid, op, thread, index, data_in, input ready);
	modport sink(input valid, op, thread, index, data_in, output ready);
endinterface

interface sags_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            ok;
	logic [sags_pkg::OUT_SLOT_W-1:0] slot;
	logic [sags_pkg::DATA_W-1:0]     data_out;
	logic [sags_pkg::ERR_W-1:0]      error;

	modport source(output valid, ok, slot, data_out, error, input ready);
	modport sink(input valid, ok, slot, data_out, error, output ready);
endinterface

// ===== src/sags_first_free.sv =====
// Priority encoder: lowest clear bit of the slot-used bitmap.
// Depends on sags_pkg.
module sags_first_free (
	input  logic [sags_pkg::NUM_SLOTS-1:0] used,
	output sags_pkg::free_t                res
);

	always_comb begin
		res = '0;
		for (int i = sags_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
			if (!used[i]) begin
				res.found = 1'b1;
				res.slot  = sags_pkg::SLOT_W'(i);
			end
		end
	end

endmodule

// ===== src/slot_allocator_generation_store.sv =====
// Top level of the slot allocator with per-thread generation-tagged value store.
// Depends on sags_pkg, sags_if and sags_first_free.

// Each request is handled in two steps: the accept edge registers the reads of the
// slot-generation memory and the per-thread entry memory, and the RMW state then
// writes back the updated generation and entry and loads the response
// register. One request is in flight at a time; a finished response may sit
// in the response register while the next request is accepted, and the
// write-back stalls only while that register is still full. The used bitmap
// lives in flops and a priority encoder picks the lowest free slot. After
// reset a clearing pass over all NUM_SLOTS*NUM_THREADS entry addresses zeroes both
// memories; no request is accepted until it ends.
module slot_allocator_generation_store (
	input  logic        clk,
	input  logic        arst_n,
	sags_req_if.sink    req,
	sags_rsp_if.source  rsp
);

	localparam int SLOT_W = sags_pkg::SLOT_W;
	localparam int ENT_W  = sags_pkg::ENT_W;
	localparam int GEN_W  = sags_pkg::GEN_W;
	localparam int DATA_W = sags_pkg::DATA_W;

	// state memories
	logic [GEN_W-1:0]     gen_mem [sags_pkg::NUM_SLOTS];
	sags_pkg::entry_t     ent_mem [sags_pkg::ENT_DEPTH];

	logic [sags_pkg::NUM_SLOTS-1:0] used_q;
	sags_pkg::state_t     state_q, state_d;
	logic [ENT_W-1:0]     clr_cnt_q;

	// control
	logic                 accept;
	logic                 rmw_done;
	logic                 clearing;

	// request decode
	sags_pkg::op_t        op_in;
	sags_pkg::free_t      ff;
	logic                 thread_ok;
	logic                 idx_ok;
	logic                 idx_used;
	logic [SLOT_W-1:0]    idx_slot;
	logic [SLOT_W-1:0]    sel_slot;
	logic [ENT_W-1:0]     addr_in;
	logic                 ok_in;
	sags_pkg::err_t       err_in;

	// stage 1 (between read and write-back)
	sags_pkg::op_t        op_s1;
	logic                 ok_s1;
	sags_pkg::err_t       err_s1;
	logic [SLOT_W-1:0]    slot_s1;
	logic [ENT_W-1:0]     addr_s1;
	logic [DATA_W-1:0]    data_s1;
	logic [GEN_W-1:0]     gen_rd_s1;
	sags_pkg::entry_t     ent_rd_s1;

	// write-back
	logic [GEN_W-1:0]     new_gen;
	sags_pkg::entry_t     fresh;
	sags_pkg::entry_t     ent_upd;
	logic                 gen_we;
	logic [SLOT_W-1:0]    gen_wa;
	logic [GEN_W-1:0]     gen_wd;
	logic                 ent_we;
	logic [ENT_W-1:0]     ent_wa;
	sags_pkg::entry_t     ent_wd;

	// response register
	logic                 rsp_valid_q;
	logic                 ok_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [DATA_W-1:0]    data_q;
	sags_pkg::err_t       err_q;

	sags_first_free u_first_free (
		.used (used_q),
		.res  (ff)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sags_pkg::ST_CLEAR: begin
				if (clr_cnt_q == ENT_W'(sags_pkg::ENT_DEPTH - 1)) state_d = sags_pkg::ST_IDLE;
			end
			sags_pkg::ST_IDLE: begin
				if (req.valid) state_d = sags_pkg::ST_RMW;
			end
			sags_pkg::ST_RMW: begin
				if (!rsp_valid_q || rsp.ready) state_d = sags_pkg::ST_IDLE;
			end
			default: state_d = sags_pkg::ST_CLEAR;
		endcase
	end

	// state outputs
	always_comb begin
		req.ready = 1'b0;
		rmw_done  = 1'b0;
		clearing  = 1'b0;
		unique case (state_q)
			sags_pkg::ST_CLEAR: clearing  = 1'b1;
			sags_pkg::ST_IDLE:  req.ready = 1'b1;
			sags_pkg::ST_RMW:   rmw_done  = !rsp_valid_q || rsp.ready;
			default: ;
		endcase
	end

	assign accept = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sags_pkg::ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (clearing) clr_cnt_q <= clr_cnt_q + ENT_W'(1);
		end
	end

	// request decode
	always_comb begin
		op_in     = sags_pkg::op_t'(req.op);
		thread_ok = int'(req.thread) < sags_pkg::NUM_THREADS;
		idx_ok    = int'(req.index) < sags_pkg::NUM_SLOTS;
		idx_slot  = req.index[SLOT_W-1:0];
		idx_used  = idx_ok && used_q[idx_slot];
		sel_slot  = (op_in == sags_pkg::OP_ALLOC) ? ff.slot : idx_slot;
		addr_in   = ENT_W'(int'(req.thread) * sags_pkg::NUM_SLOTS + int'(sel_slot));
		priority if (!thread_ok) begin
			ok_in  = 1'b0;
			err_in = sags_pkg::ERR_INVALID;
		end else if (op_in == sags_pkg::OP_ALLOC) begin
			ok_in  = ff.found;
			err_in = ff.found ? sags_pkg::ERR_NONE : sags_pkg::ERR_NO_SLOTS;
		end else begin
			ok_in  = idx_used;
			err_in = idx_used ? sags_pkg::ERR_NONE : sags_pkg::ERR_INVALID;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op_in;
			ok_s1   <= ok_in;
			err_s1  <= err_in;
			slot_s1 <= sel_slot;
			addr_s1 <= addr_in;
			data_s1 <= req.data_in;
		end
	end

	// write-back: bump generation on allocate, clear stale entry, apply set
	always_comb begin
		new_gen = (op_s1 == sags_pkg::OP_ALLOC) ? gen_rd_s1 + GEN_W'(1) : gen_rd_s1;
		fresh   = ent_rd_s1;
		if (ent_rd_s1.gen != new_gen) begin
			fresh.gen   = new_gen;
			fresh.value = '0;
		end
		ent_upd = fresh;
		if (op_s1 == sags_pkg::OP_SET) ent_upd.value = data_s1;
	end

	// memory write ports
	always_comb begin
		if (clearing) begin
			gen_we = int'(clr_cnt_q) < sags_pkg::NUM_SLOTS;
			gen_wa = clr_cnt_q[SLOT_W-1:0];
			gen_wd = '0;
			ent_we = 1'b1;
			ent_wa = clr_cnt_q;
			ent_wd = '0;
		end else begin
			gen_we = rmw_done && ok_s1 && (op_s1 == sags_pkg::OP_ALLOC);
			gen_wa = slot_s1;
			gen_wd = new_gen;
			ent_we = rmw_done && ok_s1 && (op_s1 != sags_pkg::OP_FREE);
			ent_wa = addr_s1;
			ent_wd = ent_upd;
		end
	end

	always_ff @(posedge clk) begin
		if (gen_we) gen_mem[gen_wa] <= gen_wd;
		if (ent_we) ent_mem[ent_wa] <= ent_wd;
		if (accept) begin
			gen_rd_s1 <= gen_mem[sel_slot];
			ent_rd_s1 <= ent_mem[addr_in];
		end
	end

	// used bitmap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (rmw_done && ok_s1) begin
			if (op_s1 == sags_pkg::OP_ALLOC) used_q[slot_s1] <= 1'b1;
			else if (op_s1 == sags_pkg::OP_FREE) used_q[slot_s1] <= 1'b0;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rmw_done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rmw_done) begin
			ok_q   <= ok_s1;
			err_q  <= err_s1;
			slot_q <= (ok_s1 && op_s1 == sags_pkg::OP_ALLOC) ? slot_s1 : '0;
			data_q <= (ok_s1 && op_s1 == sags_pkg::OP_GET) ? fresh.value : '0;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.ok       = ok_q;
	assign rsp.slot     = sags_pkg::OUT_SLOT_W'(slot_q);
	assign rsp.data_out = data_q;
	assign rsp.error    = err_q;

endmodule
